### src/huffman_table_encoder_xor_packer_core_assert.svh
// Assertion helpers for the encoder core.
`ifndef HUFFMAN_TABLE_ENCODER_XOR_PACKER_CORE_ASSERT_SVH
`define HUFFMAN_TABLE_ENCODER_XOR_PACKER_CORE_ASSERT_SVH

// Same-cycle implication, reset disables the check.
`define HTXP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset disables the check.
`define HTXP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/htxp_pkg.sv
`default_nettype none

package htxp_pkg;

    localparam int TABLE_DEPTH_DEF   = 256;
    localparam int MAX_CODE_BITS_DEF = 32;
    localparam int MAX_KEY_BYTES     = 16;
    // Four key words hold at most 16 bytes.
    localparam int KEY_CAP = (MAX_KEY_BYTES < 16) ? MAX_KEY_BYTES : 16;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] REG_KEY_WORD0  = 3'd1;
    localparam logic [2:0] REG_KEY_WORD1  = 3'd2;
    localparam logic [2:0] REG_KEY_WORD2  = 3'd3;
    localparam logic [2:0] REG_KEY_WORD3  = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  symbol;
        logic [31:0] code_bits;
        logic [5:0]  code_length;
    } htxp_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       last;
    } htxp_result_t;

    // Request handed from the table read stage to the packer.
    typedef struct packed {
        logic        valid;
        logic        flush;
        logic [5:0]  len;
        logic [31:0] code;
    } htxp_pk_item_t;

    typedef enum logic {
        PH_RUN,
        PH_FLUSH
    } htxp_phase_t;

endpackage

`default_nettype wire

### src/htxp_code_table.sv
`default_nettype none

module htxp_code_table #(
    parameter int TABLE_DEPTH   = htxp_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_CODE_BITS = htxp_pkg::MAX_CODE_BITS_DEF,
    localparam int CODE_W = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32,
    localparam int LEN_W  = $clog2(CODE_W + 1),
    localparam int IDX_W  = $clog2(TABLE_DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire logic [31:0]       wr_code_bits,
    input  wire logic [5:0]        wr_code_length,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output logic      [CODE_W-1:0] rd_code,
    output logic      [LEN_W-1:0]  rd_len
);

    logic [5:0]              clen;
    logic [31:0]             mask;
    logic [31:0]             masked;
    logic [LEN_W+CODE_W-1:0] mem [TABLE_DEPTH];
    logic [LEN_W+CODE_W-1:0] rd_entry_reg;

    // Saturate the length, keep only the low code bits.
    always_comb
    begin
        clen   = (wr_code_length > 6'(CODE_W)) ? 6'(CODE_W) : wr_code_length;
        mask   = (clen >= 6'd32) ? {32{1'b1}} : ~({32{1'b1}} << clen);
        masked = wr_code_bits & mask;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {clen[LEN_W-1:0], masked[CODE_W-1:0]};
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_code = rd_entry_reg[CODE_W-1:0];
    assign rd_len  = rd_entry_reg[LEN_W+CODE_W-1:CODE_W];

endmodule

`default_nettype wire

### src/htxp_packer.sv
`default_nettype none
`include "huffman_table_encoder_xor_packer_core_assert.svh"

module htxp_packer #(
    parameter int MAX_CODE_BITS = htxp_pkg::MAX_CODE_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [31:0]            cfg_data,
    input  wire htxp_pkg::htxp_pk_item_t pk_item,
    output logic                        pk_ready,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output htxp_pkg::htxp_result_t      result
);

    import htxp_pkg::*;

    localparam int CODE_W = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32;
    localparam int ACC_W  = CODE_W + 7;
    localparam int CNT_W  = $clog2(ACC_W + 1);

    logic [4:0]       key_len_reg;
    logic [31:0]      key_word_reg [4];

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       pad_reg, pad_next;
    logic [3:0]       keypos_reg, keypos_next;
    htxp_phase_t      phase_reg, phase_next;
    logic             out_valid_reg, out_valid_next;
    htxp_result_t     out_data_reg, out_data_next;

    logic [4:0]       eff_len;
    logic             key_on;
    logic [4:0]       pos_cur;
    logic [4:0]       pos_inc;
    logic [31:0]      key_word;
    logic [31:0]      key_shift;
    logic [7:0]       key_byte;
    logic [3:0]       pos_adv;
    logic             slot_free;
    logic             hdr_emit;
    logic [CNT_W-1:0] cnt_rem;
    logic [ACC_W-1:0] acc_shr;
    logic [ACC_W-1:0] acc_pad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg     <= '0;
            key_word_reg[0] <= '0;
            key_word_reg[1] <= '0;
            key_word_reg[2] <= '0;
            key_word_reg[3] <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KEY_LENGTH: key_len_reg     <= cfg_data[4:0];
                REG_KEY_WORD0:  key_word_reg[0] <= cfg_data;
                REG_KEY_WORD1:  key_word_reg[1] <= cfg_data;
                REG_KEY_WORD2:  key_word_reg[2] <= cfg_data;
                REG_KEY_WORD3:  key_word_reg[3] <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Key byte for the next keyed output; restarts at byte 0 if position ran past length.
    always_comb
    begin
        eff_len   = (key_len_reg > 5'(KEY_CAP)) ? 5'(KEY_CAP) : key_len_reg;
        key_on    = (eff_len != 5'd0);
        pos_cur   = ({1'b0, keypos_reg} >= eff_len) ? 5'd0 : {1'b0, keypos_reg};
        key_word  = key_word_reg[pos_cur[3:2]];
        key_shift = key_word >> {pos_cur[1:0], 3'b000};
        key_byte  = key_on ? key_shift[7:0] : 8'h00;
        pos_inc   = pos_cur + 5'd1;
        if (!key_on)
        begin
            pos_adv = keypos_reg;
        end
        else if (pos_inc >= eff_len)
        begin
            pos_adv = 4'd0;
        end
        else
        begin
            pos_adv = pos_inc[3:0];
        end
    end

    always_comb
    begin
        slot_free = !out_valid_reg || result_ready;
        pk_ready  = (phase_reg == PH_RUN) && (cnt_reg < CNT_W'(8));
        cnt_rem   = cnt_reg - CNT_W'(8);
        acc_shr   = acc_reg >> cnt_rem;
        acc_pad   = acc_reg << pad_reg;

        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        pad_next       = pad_reg;
        keypos_next    = keypos_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_data_next  = out_data_reg;
        hdr_emit       = 1'b0;

        case (phase_reg)
            PH_RUN:
            begin
                if (pk_item.valid && pk_ready)
                begin
                    if (pk_item.flush)
                    begin
                        phase_next = PH_FLUSH;
                        pad_next   = 3'd0 - cnt_reg[2:0];
                    end
                    else
                    begin
                        acc_next = (acc_reg << pk_item.len)
                                 | {7'd0, pk_item.code[CODE_W-1:0]};
                        cnt_next = cnt_reg + CNT_W'(pk_item.len);
                    end
                end
                else if ((cnt_reg >= CNT_W'(8)) && slot_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.out_byte  = acc_shr[7:0] ^ key_byte;
                    out_data_next.is_header = 1'b0;
                    out_data_next.last      = (cnt_rem < CNT_W'(8));
                    cnt_next                = cnt_rem;
                    keypos_next             = pos_adv;
                end
            end
            PH_FLUSH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (cnt_reg != '0)
                    begin
                        // zero-padded partial byte, keyed like data
                        out_data_next.out_byte  = acc_pad[7:0] ^ key_byte;
                        out_data_next.is_header = 1'b0;
                        out_data_next.last      = 1'b0;
                        cnt_next                = '0;
                        keypos_next             = pos_adv;
                    end
                    else
                    begin
                        hdr_emit                = 1'b1;
                        out_data_next.out_byte  = {4'd0, key_on, pad_reg};
                        out_data_next.is_header = 1'b1;
                        out_data_next.last      = 1'b1;
                        keypos_next             = 4'd0;
                        phase_next              = PH_RUN;
                    end
                end
            end
            default:
            begin
                phase_next = PH_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pad_reg       <= '0;
            keypos_reg    <= '0;
            phase_reg     <= PH_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            pad_reg       <= pad_next;
            keypos_reg    <= keypos_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    `HTXP_ASSERT_NOW(a_hdr_is_last, clk, rst_n,
        out_valid_reg && out_data_reg.is_header, out_data_reg.last,
        "header result without last")
    `HTXP_ASSERT_NOW(a_no_take_in_flush, clk, rst_n,
        phase_reg == PH_FLUSH, !pk_ready,
        "request taken during flush")
    `HTXP_ASSERT_NEXT(a_hdr_clears, clk, rst_n,
        hdr_emit,
        (cnt_reg == '0) && (keypos_reg == 4'd0) && (phase_reg == PH_RUN),
        "state not cleared after header")

endmodule

`default_nettype wire

### src/huffman_table_encoder_xor_packer_core.sv
// Channel   Signals                          Payload
// item      item_valid / item_ready          htxp_item_t (operation, symbol, code)
// result    result_valid / result_ready      htxp_result_t (out_byte, is_header, last)
// cfg       cfg_write / cfg_index / cfg_data key length and four key words
//
// A request is taken every cycle while the table-read stage is free or drains.
// Load: written into the code table at acceptance if the symbol is in range.
// Encode: the read stage registers the table read; the packer merges it into the
// accumulator, sends out whole bytes and takes the next request once under eight
// bits remain. Flush: passes the read stage; the packer emits the zero-padded
// partial byte, if any, then the header. The packer's single output register bounds
// throughput to one byte per cycle. Reset clears the accumulator bit count, key
// position and key registers; the table holds no reset state. A stalled result
// holds the packer's bytes; a request waits in the read stage.
`default_nettype none

module huffman_table_encoder_xor_packer_core #(
    parameter int TABLE_DEPTH   = htxp_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_CODE_BITS = htxp_pkg::MAX_CODE_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [31:0]            cfg_data,
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire htxp_pkg::htxp_item_t   item,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output htxp_pkg::htxp_result_t      result
);

    import htxp_pkg::*;

    localparam int CODE_W = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32;
    localparam int LEN_W  = $clog2(CODE_W + 1);
    localparam int IDX_W  = $clog2(TABLE_DEPTH);

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_flush_reg, s1_flush_next;
    logic              s1_hit_reg, s1_hit_next;
    logic              accept;
    logic              in_range;
    logic              tbl_wr;
    logic              tbl_rd;
    logic [CODE_W-1:0] rd_code;
    logic [LEN_W-1:0]  rd_len;
    logic              pk_ready;
    htxp_pk_item_t     pk_item;

    always_comb
    begin
        item_ready = !s1_valid_reg || pk_ready;
        accept     = item_valid && item_ready;
        in_range   = ({1'b0, item.symbol} < 9'(TABLE_DEPTH));
        tbl_wr     = accept && (item.operation == OP_LOAD) && in_range;
        tbl_rd     = accept && (item.operation == OP_ENCODE);

        s1_valid_next = s1_valid_reg && !pk_ready;
        s1_flush_next = s1_flush_reg;
        s1_hit_next   = s1_hit_reg;
        if (accept && ((item.operation == OP_ENCODE) || (item.operation == OP_FLUSH)))
        begin
            s1_valid_next = 1'b1;
            s1_flush_next = (item.operation == OP_FLUSH);
            s1_hit_next   = in_range;
        end

        pk_item.valid = s1_valid_reg;
        pk_item.flush = s1_flush_reg;
        pk_item.len   = s1_hit_reg ? 6'(rd_len) : 6'd0;
        pk_item.code  = s1_hit_reg ? 32'(rd_code) : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_flush_reg <= s1_flush_next;
        s1_hit_reg   <= s1_hit_next;
    end

    htxp_code_table #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_table (
        .clk            (clk),
        .wr_en          (tbl_wr),
        .wr_addr        (item.symbol[IDX_W-1:0]),
        .wr_code_bits   (item.code_bits),
        .wr_code_length (item.code_length),
        .rd_en          (tbl_rd),
        .rd_addr        (item.symbol[IDX_W-1:0]),
        .rd_code        (rd_code),
        .rd_len         (rd_len)
    );

    htxp_packer #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pk_item      (pk_item),
        .pk_ready     (pk_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire
